/* rtl/sample_histogram_peak_tracker_defines.svh */
// ----------------------------------------------------------------------------
// Histogram peak tracker assertion macros
// Shared concurrent assertion forms, clocked on clock, held off by reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_HISTOGRAM_PEAK_TRACKER_DEFINES_SVH
`define SAMPLE_HISTOGRAM_PEAK_TRACKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SHPT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SHPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/shpt_pkg.sv */
// ----------------------------------------------------------------------------
// Histogram peak tracker package
// Sizes, field types and command codes shared by the channels and the core.
// ----------------------------------------------------------------------------
package shpt_pkg;

   // Number of bins; a power of two, the bin is the low bits of the sample.
   localparam int BIN_COUNT       = 4096;
   localparam int COUNT_WIDTH     = 16;
   localparam int IDX_WIDTH       = $clog2(BIN_COUNT);
   localparam int SAMPLE_WIDTH    = 12;
   localparam int OUT_COUNT_WIDTH = 16;

   typedef logic [SAMPLE_WIDTH-1:0]    sample_type;
   typedef logic [COUNT_WIDTH-1:0]     count_type;
   typedef logic [OUT_COUNT_WIDTH-1:0] out_count_type;
   typedef logic [IDX_WIDTH-1:0]       index_type;

   localparam count_type  COUNT_MAX      = '1;
   localparam index_type  BIN_LAST       = IDX_WIDTH'(BIN_COUNT - 1);
   localparam sample_type HALF_WIDTH_RST = SAMPLE_WIDTH'(64);

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

endpackage

/* rtl/shpt_channels.sv */
// ----------------------------------------------------------------------------
// Histogram peak tracker channels
// Valid/ready interfaces for the request, response and register write words.
// ----------------------------------------------------------------------------
interface shpt_req_if;
   import shpt_pkg::*;

   logic       valid;
   logic       ready;
   logic       command;
   sample_type sample;
   logic       first_of_batch;

   modport source (output valid, command, sample, first_of_batch, input ready);
   modport sink (input valid, command, sample, first_of_batch, output ready);
endinterface

interface shpt_rsp_if;
   import shpt_pkg::*;

   logic          valid;
   logic          ready;
   out_count_type bin_count;
   out_count_type min_count;
   out_count_type max_count;
   sample_type    window_start;
   logic          saturated;

   modport source (output valid, bin_count, min_count, max_count, window_start,
                   saturated, input ready);
   modport sink (input valid, bin_count, min_count, max_count, window_start,
                 saturated, output ready);
endinterface

interface shpt_csr_if;
   import shpt_pkg::*;

   logic       valid;
   logic       ready;
   sample_type window_half_width;

   modport source (output valid, window_half_width, input ready);
   modport sink (input valid, window_half_width, output ready);
endinterface

/* rtl/sample_histogram_peak_tracker.sv */
// ----------------------------------------------------------------------------
// Sample histogram peak tracker
// Bins converter samples in an on-chip count RAM and tracks the min, max and
// display window start over the counts of the current batch.
// ----------------------------------------------------------------------------
// An add word increments the bin picked by the low bits of its sample (the
// count sticks at all ones and flags saturated) and answers with the new bin
// count, the min and max trackers and the window start, which moves to sample
// minus the half width (floored at 0) whenever a new max shows up. A set
// first_of_batch reloads both trackers from the bin's old count. A clear word
// answers at once with bin_count 0 and the unchanged trackers, then zeroes the
// RAM one bin per cycle, all BIN_COUNT (4096) bins, and no request is taken
// while it sweeps. The same sweep runs after reset, so the first request is
// taken only once it has finished. Adds stream at one word per cycle for as
// long as responses are taken: the bin RAM is read on acceptance, and the
// count is incremented and written back when the word leaves stage 1, with
// the previous write forwarded when two back-to-back words hit the same bin.
// The response word is held in a register after stage 1. The window half width
// register is written through the csr channel, which is always ready, and
// should only be written while no word is in flight.
// ----------------------------------------------------------------------------
`include "sample_histogram_peak_tracker_defines.svh"

module sample_histogram_peak_tracker (
   input  logic       clock,
   input  logic       reset,
   shpt_req_if.sink   req_chan,
   shpt_rsp_if.source rsp_chan,
   shpt_csr_if.sink   csr_chan
);
   import shpt_pkg::*;

   // Clear sweep over the bin RAM.
   logic       sweep_ff, sweep_in;
   index_type  sweep_cnt_ff, sweep_cnt_in;

   // Stage 1: word whose bin read is in flight or returned.
   logic       s1_valid_ff;
   logic       s1_command_ff;
   sample_type s1_sample_ff;
   logic       s1_first_ff;

   // Last item write, for same-bin forwarding.
   logic       fwd_valid_ff, fwd_valid_in;
   index_type  fwd_addr_ff;
   count_type  fwd_data_ff;

   // Trackers and registers.
   count_type  min_ff, min_in;
   count_type  max_ff, max_in;
   sample_type window_ff, window_in;
   sample_type half_width_ff;

   // Response word register.
   logic          rsp_valid_ff;
   out_count_type rsp_bin_ff;
   out_count_type rsp_min_ff;
   out_count_type rsp_max_ff;
   sample_type    rsp_window_ff;
   logic          rsp_sat_ff;

   logic       out_free;
   logic       s1_adv;
   logic       s1_stall;
   logic       req_accept;
   index_type  s1_idx;
   index_type  rd_addr;
   count_type  rd_data;
   logic       wr_en;
   index_type  wr_addr;
   count_type  wr_data;
   count_type  old_count;
   count_type  now_count;
   count_type  base_min;
   count_type  base_max;
   logic       sat;
   logic       s1_is_add;

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s1_is_add  = (s1_command_ff == CMD_ADD);
   assign s1_adv     = s1_valid_ff && out_free;
   assign s1_stall   = s1_valid_ff && !out_free;

   // Hold requests during a sweep and behind a clear that has not left stage 1,
   // so no bin read can slip in ahead of the zeroing.
   assign req_chan.ready = !sweep_ff && (!s1_valid_ff || (out_free && s1_is_add));
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // ---------------------------------------------------------------------
   // Bin RAM access
   // ---------------------------------------------------------------------
   // Re-read the stalled word's bin every cycle, so its read data stays
   // current while the response side is blocked.
   assign s1_idx  = IDX_WIDTH'(s1_sample_ff);
   assign rd_addr = s1_stall ? s1_idx : IDX_WIDTH'(req_chan.sample);

   assign wr_en   = sweep_ff || (s1_adv && s1_is_add);
   assign wr_addr = sweep_ff ? sweep_cnt_ff : s1_idx;
   assign wr_data = sweep_ff ? '0 : now_count;

   shpt_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BIN_COUNT)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------
   // Increment and tracker update
   // ---------------------------------------------------------------------
   always_comb begin
      // The RAM read raced the previous word's write to the same bin: take
      // the written count instead.
      if (fwd_valid_ff && (fwd_addr_ff == s1_idx)) begin
         old_count = fwd_data_ff;
      end else begin
         old_count = rd_data;
      end

      sat       = (old_count == COUNT_MAX);
      now_count = sat ? old_count : old_count + 1'b1;

      base_min  = s1_first_ff ? old_count : min_ff;
      base_max  = s1_first_ff ? old_count : max_ff;

      min_in    = min_ff;
      max_in    = max_ff;
      window_in = window_ff;
      if (s1_adv && s1_is_add) begin
         min_in = (now_count < base_min) ? now_count : base_min;
         max_in = base_max;
         if (now_count > base_max) begin
            // New peak: move the window, floored at zero.
            max_in    = now_count;
            window_in = (s1_sample_ff >= half_width_ff) ?
                        (s1_sample_ff - half_width_ff) : '0;
         end
      end
   end

   always_comb begin
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
         if (sweep_cnt_ff == BIN_LAST) begin
            sweep_in     = 1'b0;
            sweep_cnt_in = '0;
         end
      end else if (s1_adv && !s1_is_add) begin
         sweep_in = 1'b1;
      end
   end

   assign fwd_valid_in = s1_adv && s1_is_add;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_cnt_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         min_ff        <= '0;
         max_ff        <= '0;
         window_ff     <= '0;
         half_width_ff <= HALF_WIDTH_RST;
      end else begin
         sweep_ff     <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
         s1_valid_ff  <= req_accept || s1_stall;
         fwd_valid_ff <= fwd_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         window_ff    <= window_in;
         if (csr_chan.valid) begin
            half_width_ff <= csr_chan.window_half_width;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_command_ff <= req_chan.command;
         s1_sample_ff  <= req_chan.sample;
         s1_first_ff   <= req_chan.first_of_batch;
      end
      fwd_addr_ff <= s1_idx;
      fwd_data_ff <= now_count;
      if (s1_adv) begin
         // Trackers go out as they stand after this word.
         rsp_bin_ff    <= s1_is_add ? OUT_COUNT_WIDTH'(now_count) : '0;
         rsp_sat_ff    <= s1_is_add && sat;
         rsp_min_ff    <= OUT_COUNT_WIDTH'(min_in);
         rsp_max_ff    <= OUT_COUNT_WIDTH'(max_in);
         rsp_window_ff <= window_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.bin_count    = rsp_bin_ff;
   assign rsp_chan.min_count    = rsp_min_ff;
   assign rsp_chan.max_count    = rsp_max_ff;
   assign rsp_chan.window_start = rsp_window_ff;
   assign rsp_chan.saturated    = rsp_sat_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `SHPT_ASSERT_NOW(a_no_req_in_sweep, sweep_ff, !req_chan.ready, "request taken during sweep")
   `SHPT_ASSERT_NOW(a_tracker_order, 1'b1, min_ff <= max_ff, "min tracker above max tracker")
   `SHPT_ASSERT_NEXT(a_clear_sweeps, s1_adv && !s1_is_add, sweep_ff && (sweep_cnt_ff == '0), "clear did not start a sweep")
   `SHPT_ASSERT_NOW(a_sweep_full, $fell(sweep_ff), $past(sweep_cnt_ff) == BIN_LAST, "sweep ended early")
   `SHPT_ASSERT_NEXT(a_stall_holds, s1_stall, s1_valid_ff && $stable(s1_sample_ff), "stalled word lost")

endmodule

/* rtl/shpt_ram.sv */
// ----------------------------------------------------------------------------
// Histogram peak tracker RAM
// Simple dual-port RAM: one write port, one read port, registered read data,
// old data returned on a read of the address being written.
// ----------------------------------------------------------------------------
module shpt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* bench/sample_histogram_peak_tracker_tb.sv */
// ----------------------------------------------------------------------------
// Sample histogram peak tracker testbench
// Streams add and clear words through the request channel, predicts every
// response word from a local histogram with its own min/max trackers and
// window start, and checks each response field by field. Half-width writes go
// in between phases while the block is idle. Both channels idle at random.
// ----------------------------------------------------------------------------
module sample_histogram_peak_tracker_tb;
   import shpt_pkg::*;

   // Generous ceiling: well above the slowest correct run, clear sweeps and
   // stalls included.
   localparam longint LIMIT_CYCLES = 3_000_000;
   localparam int     RANDOM_WORDS = 1560;
   localparam int     PHASES       = 6;
   localparam int     STREAK_WORDS = 40;

   typedef struct packed {
      out_count_type bin_count;
      out_count_type min_count;
      out_count_type max_count;
      sample_type    window_start;
      logic          saturated;
   } bin_report_type;

   logic clock;
   logic reset;

   shpt_req_if req_bus ();
   shpt_rsp_if rsp_bus ();
   shpt_csr_if csr_bus ();

   sample_histogram_peak_tracker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Local copy of the histogram and the tracker state.
   count_type  bin_model [BIN_COUNT];
   count_type  min_model    = '0;
   count_type  max_model    = '0;
   sample_type window_model = '0;
   sample_type half_model   = HALF_WIDTH_RST;

   bin_report_type reports_due [$];

   int  mismatches     = 0;
   int  reports_seen   = 0;
   int  saturated_seen = 0;
   int  adds_sent      = 0;
   int  clears_sent    = 0;
   int  half_writes    = 0;
   int  rsp_stall_left = 0;
   bit  no_idle        = 1'b0;

   // Clock: 10 time units per period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // Apply one word to the local histogram and return the response it earns.
   function automatic bin_report_type histogram_update(logic cmd, sample_type smp,
                                                       logic first);
      bin_report_type rpt;
      index_type      bin;
      count_type      old_count;
      count_type      new_count;
      logic           sat;
      bin = index_type'(smp);
      if (cmd == CMD_CLEAR) begin
         // Clear leaves the trackers and the window start alone.
         foreach (bin_model[i])
            bin_model[i] = '0;
         rpt.bin_count = '0;
         rpt.saturated = 1'b0;
      end else begin
         old_count = bin_model[bin];
         // Restart the batch from the bin's count before the increment.
         if (first) begin
            min_model = old_count;
            max_model = old_count;
         end
         sat       = (old_count == COUNT_MAX);
         new_count = sat ? old_count : count_type'(old_count + 1'b1);
         bin_model[bin] = new_count;
         if (new_count < min_model)
            min_model = new_count;
         // Move the window only on a strictly new peak; floor it at zero.
         if (new_count > max_model) begin
            max_model    = new_count;
            window_model = (smp >= half_model) ? sample_type'(smp - half_model) : '0;
         end
         rpt.bin_count = out_count_type'(new_count);
         rpt.saturated = sat;
      end
      rpt.min_count    = out_count_type'(min_model);
      rpt.max_count    = out_count_type'(max_model);
      rpt.window_start = window_model;
      return rpt;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 30)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Drive response-side backpressure: hold ready low for a random stall,
   // then raise it and maybe pick the next stall.
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_bus.ready  <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!no_idle)
            rsp_stall_left <= pick_gap();
      end
   end

   // Sample all three channels at each edge. Predict before checking, so a
   // word accepted on one edge is queued ahead of any later response.
   always @(posedge clock) begin
      bin_report_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            half_model = csr_bus.window_half_width;
         if (req_bus.valid && req_bus.ready)
            reports_due.push_back(histogram_update(req_bus.command, req_bus.sample,
                                                   req_bus.first_of_batch));
         if (rsp_bus.valid && rsp_bus.ready) begin
            reports_seen++;
            if (rsp_bus.saturated === 1'b1)
               saturated_seen++;
            if (reports_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 30)
                  $display("%0t: response word with none expected, bin_count %0d",
                           $time, rsp_bus.bin_count);
            end else begin
               want = reports_due.pop_front();
               check_field("bin_count", want.bin_count, rsp_bus.bin_count);
               check_field("min_count", want.min_count, rsp_bus.min_count);
               check_field("max_count", want.max_count, rsp_bus.max_count);
               check_field("window_start", 16'(want.window_start),
                           16'(rsp_bus.window_start));
               check_field("saturated", 16'(want.saturated), 16'(rsp_bus.saturated));
            end
         end
      end
   end

   // Send one request word; return on the edge that accepts it, valid still
   // high so the next word can follow without a bubble.
   task automatic send_word(logic cmd, sample_type smp, logic first);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.command        <= cmd;
      req_bus.sample         <= smp;
      req_bus.first_of_batch <= first;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (cmd == CMD_CLEAR)
         clears_sent++;
      else
         adds_sent++;
   endtask

   task automatic add_sample(sample_type smp, logic first);
      send_word(CMD_ADD, smp, first);
   endtask

   // Drop valid, wait for every expected response, then idle for extra more edges.
   task automatic settle_idle(int extra);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (reports_due.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Call only after settle_idle.
   task automatic write_half_width(sample_type value);
      csr_bus.valid             <= 1'b1;
      csr_bus.window_half_width <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
      half_writes++;
      @(posedge clock);
   endtask

   // Field extremes, bin reuse back to back, batch restarts, window clamping
   // around the reset half width, and a clear in the middle.
   task automatic test_directed_fields();
      add_sample(12'h000, 1'b0);
      add_sample(12'h000, 1'b0);
      add_sample(12'hFFF, 1'b0);
      add_sample(12'hFFF, 1'b1);
      add_sample(12'hAAA, 1'b0);
      add_sample(12'h555, 1'b1);
      add_sample(12'd63, 1'b1);
      add_sample(12'd64, 1'b1);
      add_sample(12'd65, 1'b1);
      add_sample(12'd65, 1'b0);
      add_sample(12'd63, 1'b0);
      send_word(CMD_CLEAR, 12'hFFF, 1'b1);
      add_sample(12'h000, 1'b0);
      add_sample(12'h000, 1'b1);
      add_sample(12'hFFF, 1'b0);
      settle_idle(8);
   endtask

   // Half width at both extremes, then back to the reset value.
   task automatic test_window_width();
      write_half_width(12'd0);
      add_sample(12'hFFF, 1'b1);
      add_sample(12'h000, 1'b1);
      add_sample(12'h800, 1'b1);
      settle_idle(8);
      write_half_width(12'hFFF);
      add_sample(12'hFFE, 1'b1);
      add_sample(12'hFFF, 1'b1);
      add_sample(12'hFFF, 1'b0);
      settle_idle(8);
      write_half_width(HALF_WIDTH_RST);
   endtask

   // Hammer one bin back to back with no idling, restart a batch on it, touch
   // its neighbor in between, then clear.
   task automatic test_hot_bin_streak();
      sample_type hot;
      hot     = sample_type'($urandom);
      no_idle = 1'b1;
      send_word(CMD_CLEAR, 12'h000, 1'b0);
      add_sample(hot, 1'b1);
      for (int i = 0; i < STREAK_WORDS; i++)
         add_sample(hot, 1'b0);
      add_sample(hot, 1'b1);
      add_sample(sample_type'(hot + 1'b1), 1'b0);
      add_sample(hot, 1'b0);
      send_word(CMD_CLEAR, hot, 1'b1);
      settle_idle(8);
      no_idle = 1'b0;
   endtask

   // Batches that open with first_of_batch and stay mostly on a few hot bins,
   // mixed with lone random words and rare clears. Each phase runs under a new
   // half width; one phase runs with no idling at all.
   task automatic test_random_batches();
      sample_type hot_bins [4];
      sample_type smp;
      int         quota;
      int         sent;
      int         roll;
      int         run;
      quota = RANDOM_WORDS / PHASES;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_idle(8);
         case (phase)
            0:       write_half_width(12'd0);
            1:       write_half_width(12'hFFF);
            2:       write_half_width(sample_type'($urandom_range(0, 128)));
            default: write_half_width(sample_type'($urandom));
         endcase
         no_idle = (phase == 3);
         foreach (hot_bins[i])
            hot_bins[i] = sample_type'($urandom);
         sent = 0;
         while (sent < quota) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               send_word(CMD_CLEAR, sample_type'($urandom), 1'($urandom));
               sent++;
            end else if (roll < 15) begin
               add_sample(sample_type'($urandom), 1'($urandom));
               sent++;
            end else begin
               run = $urandom_range(3, 20);
               for (int k = 0; k < run; k++) begin
                  if ($urandom_range(0, 9) < 7)
                     smp = hot_bins[$urandom_range(0, 3)];
                  else
                     smp = sample_type'($urandom);
                  add_sample(smp, k == 0);
                  sent++;
               end
            end
         end
      end
      no_idle = 1'b0;
      settle_idle(8);
   endtask

   initial begin
      reset                     = 1'b1;
      req_bus.valid             = 1'b0;
      req_bus.command           = CMD_ADD;
      req_bus.sample            = '0;
      req_bus.first_of_batch    = 1'b0;
      rsp_bus.ready             = 1'b0;
      csr_bus.valid             = 1'b0;
      csr_bus.window_half_width = '0;
      foreach (bin_model[i])
         bin_model[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_fields();
      test_window_width();
      test_hot_bin_streak();
      test_random_batches();

      settle_idle(16);
      $display("Run covered %0d add words, %0d clear words and %0d half-width writes.",
               adds_sent, clears_sent, half_writes);
      $display("Checked %0d response words, %0d saturated; %0d mismatches.",
               reports_seen, saturated_seen, mismatches);
      if (mismatches == 0)
         $display("** sample_histogram_peak_tracker: PASSED **");
      else
         $display("** sample_histogram_peak_tracker: FAILED **");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #(LIMIT_CYCLES * 10);
      $display("Timeout with %0d response words still expected.", reports_due.size());
      $display("** sample_histogram_peak_tracker: FAILED **");
      $finish;
   end

endmodule
